// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
module spq_cell #(
  parameter int IDX           = 0,
  parameter int CW            = 5,
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic                     clk,
  input  spq_pkg::cell_ctl_t       ctl,
  input  logic [CW-1:0]            count,
  input  logic [KEY_WIDTH-1:0]     new_key,
  input  logic [PAYLOAD_WIDTH-1:0] new_pay,
  input  logic                     prev_ahead,
  input  logic [KEY_WIDTH-1:0]     prev_key,
  input  logic [PAYLOAD_WIDTH-1:0] prev_pay,
  input  logic [KEY_WIDTH-1:0]     next_key,
  input  logic [PAYLOAD_WIDTH-1:0] next_pay,
  output logic [KEY_WIDTH-1:0]     key,
  output logic [PAYLOAD_WIDTH-1:0] pay,
  output logic                     ahead
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [KEY_WIDTH-1:0]     key_r;
  logic [KEY_WIDTH-1:0]     key_nxt;
  logic [PAYLOAD_WIDTH-1:0] pay_r;
  logic [PAYLOAD_WIDTH-1:0] pay_nxt;
  logic                     occupied;

  // new entry goes ahead of this cell: empty slot or strictly smaller key
  assign occupied = count > IDX_C;
  assign ahead    = !occupied || (key_r < new_key);

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    if (ctl.ins && ahead) begin
      if (prev_ahead) begin
        key_nxt = prev_key;
        pay_nxt = prev_pay;
      end else begin
        key_nxt = new_key;
        pay_nxt = new_pay;
      end
    end else if (ctl.rem) begin
      key_nxt = next_key;
      pay_nxt = next_pay;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key = key_r;
  assign pay = pay_r;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// the result is registered in the cycle after the request is accepted
// a new request is taken only while the output register is empty, i.e. after the
//   previous result has been taken; the cell row updates in the accept cycle
// reset: synchronous active-low rst_n empties the queue, clears the output valid
//   flag and sets capacity to 16; cell contents and output data are not reset
module sorted_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int KEY_WIDTH     = 16,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [spq_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [KEY_WIDTH-1:0]         in_key,
  input  logic [PAYLOAD_WIDTH-1:0]     in_payload,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spq_pkg::STATUS_W-1:0] out_status,
  output logic [KEY_WIDTH-1:0]         out_key,
  output logic [PAYLOAD_WIDTH-1:0]     out_payload,
  output logic [spq_pkg::COUNT_W-1:0]  out_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [spq_pkg::CAP_W-1:0] cap_r;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic                      out_valid_r;
  spq_pkg::status_t          out_status_r;
  spq_pkg::status_t          status_nxt;
  logic [KEY_WIDTH-1:0]      out_key_r;
  logic [KEY_WIDTH-1:0]      okey_nxt;
  logic [PAYLOAD_WIDTH-1:0]  out_payload_r;
  logic [PAYLOAD_WIDTH-1:0]  opay_nxt;
  logic [spq_pkg::COUNT_W-1:0] out_count_r;

  logic                      accept;
  logic                      full;
  logic [CW-1:0]             lim;
  spq_pkg::cell_ctl_t        ctl;
  spq_pkg::opcode_t          op;

  logic [KEY_WIDTH-1:0]      key_w    [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]  pay_w    [DEPTH];
  logic                      ahead_w  [DEPTH];

  assign in_stall = out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign op       = spq_pkg::opcode_t'(in_opcode);

  always_comb begin
    if (cap_r == '0) begin
      lim = CW'(1);
    end else if (int'(cap_r) > DEPTH) begin
      lim = CW'(DEPTH);
    end else begin
      lim = CW'(cap_r);
    end
  end

  assign full    = count_r >= lim;
  assign ctl.ins = accept && (op == spq_pkg::OP_INSERT) && !full;
  assign ctl.rem = accept && (op == spq_pkg::OP_REMOVE) && (count_r != '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     pb;
    logic [KEY_WIDTH-1:0]     pk;
    logic [PAYLOAD_WIDTH-1:0] pp;
    logic [KEY_WIDTH-1:0]     nk;
    logic [PAYLOAD_WIDTH-1:0] np;
    if (i == 0) begin : g_head
      assign pb = 1'b0;
      assign pk = in_key;
      assign pp = in_payload;
    end else begin : g_mid
      assign pb = ahead_w[i-1];
      assign pk = key_w[i-1];
      assign pp = pay_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign nk = key_w[i];
      assign np = pay_w[i];
    end else begin : g_body
      assign nk = key_w[i+1];
      assign np = pay_w[i+1];
    end
    spq_cell #(
      .IDX           (i),
      .CW            (CW),
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count_r),
      .new_key     (in_key),
      .new_pay     (in_payload),
      .prev_ahead  (pb),
      .prev_key    (pk),
      .prev_pay    (pp),
      .next_key    (nk),
      .next_pay    (np),
      .key         (key_w[i]),
      .pay         (pay_w[i]),
      .ahead       (ahead_w[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    okey_nxt   = '0;
    opay_nxt   = '0;
    case (op)
      spq_pkg::OP_INSERT: begin
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          okey_nxt  = key_w[0];
          opay_nxt  = pay_w[0];
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        status_nxt = spq_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= spq_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status_nxt;
      out_key_r     <= okey_nxt;
      out_payload_r <= opay_nxt;
      out_count_r   <= spq_pkg::COUNT_W'(count_nxt);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key     = out_key_r;
  assign out_payload = out_payload_r;
  assign out_count   = out_count_r;

endmodule

// ===== tb/testbench.sv =====
module testbench;

  localparam int DEPTH       = 16;
  localparam int KEY_W       = 16;
  localparam int PAY_W       = 16;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIR_ROWS    = 27;

  typedef struct packed {
    spq_pkg::status_t            status;
    logic [KEY_W-1:0]            key;
    logic [PAY_W-1:0]            payload;
    logic [spq_pkg::COUNT_W-1:0] count;
  } pq_result_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } held_entry_t;

  typedef enum logic {
    ROW_REQ = 1'b0,
    ROW_CFG = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    spq_pkg::opcode_t          op;
    logic [KEY_W-1:0]          key;
    logic [PAY_W-1:0]          payload;
    logic [spq_pkg::CAP_W-1:0] cap;
    logic                      fixed;
    pq_result_t                want;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [spq_pkg::CAP_W-1:0]    cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_opcode = 1'b0;
  logic [KEY_W-1:0]             in_key = '0;
  logic [PAY_W-1:0]             in_payload = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [spq_pkg::STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]             out_key;
  logic [PAY_W-1:0]             out_payload;
  logic [spq_pkg::COUNT_W-1:0]  out_count;

  sorted_priority_queue #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(KEY_W),
    .PAYLOAD_WIDTH(PAY_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_key(in_key),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_key(out_key),
    .out_payload(out_payload),
    .out_count(out_count)
  );

  always #5 clk = ~clk;

  held_entry_t held [$];
  pq_result_t  pending_results [$];
  logic [spq_pkg::CAP_W-1:0] cap_reg = spq_pkg::CAP_RESET;
  pq_result_t  blank_result = '0;
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;

  dir_row_t dir_tab [0:DIR_ROWS-1] = '{
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b1,
      '{spq_pkg::ST_EMPTY, 16'h0, 16'h0, 5'd0}},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 5'd0, 1'b1,
      '{spq_pkg::ST_OK, 16'h0, 16'h0, 5'd1}},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h0000, 16'h0000, 5'd0, 1'b1,
      '{spq_pkg::ST_OK, 16'h0, 16'h0, 5'd2}},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'hFFFF, 16'h1234, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h8000, 16'hAAAA, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h0000, 16'h5555, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF, 5'd0, 1'b1,
      '{spq_pkg::ST_EMPTY, 16'h0, 16'h0, 5'd0}},
    '{ROW_CFG, spq_pkg::OP_INSERT, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h1111, 16'h2222, 5'd0, 1'b1,
      '{spq_pkg::ST_OK, 16'h0, 16'h0, 5'd1}},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h3333, 16'h4444, 5'd0, 1'b1,
      '{spq_pkg::ST_FULL, 16'h0, 16'h0, 5'd1}},
    '{ROW_CFG, spq_pkg::OP_INSERT, 16'h0000, 16'h0000, 5'd3, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h7FFF, 16'h0001, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h7FFF, 16'h0002, 5'd0, 1'b0, '0},
    '{ROW_CFG, spq_pkg::OP_INSERT, 16'h0000, 16'h0000, 5'd1, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'hABCD, 16'hEF01, 5'd0, 1'b1,
      '{spq_pkg::ST_FULL, 16'h0, 16'h0, 5'd3}},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'h0001, 16'h0001, 5'd0, 1'b1,
      '{spq_pkg::ST_FULL, 16'h0, 16'h0, 5'd1}},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b0, '0},
    '{ROW_CFG, spq_pkg::OP_INSERT, 16'h0000, 16'h0000, 5'd31, 1'b0, '0},
    '{ROW_REQ, spq_pkg::OP_INSERT, 16'hFFFF, 16'h0000, 5'd0, 1'b1,
      '{spq_pkg::ST_OK, 16'h0, 16'h0, 5'd1}},
    '{ROW_REQ, spq_pkg::OP_REMOVE, 16'h0000, 16'h0000, 5'd0, 1'b1,
      '{spq_pkg::ST_OK, 16'hFFFF, 16'h0, 5'd0}}
  };

  function automatic pq_result_t apply_request(spq_pkg::opcode_t op, logic [KEY_W-1:0] key,
                                               logic [PAY_W-1:0] pay);
    pq_result_t  r;
    held_entry_t e;
    int          pos;
    int          lim;
    r = '0;
    r.status = spq_pkg::ST_OK;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
    if (op == spq_pkg::OP_INSERT) begin
      if (held.size() >= lim) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held.size() && held[pos].key >= key) pos++;
        e.key = key;
        e.payload = pay;
        held.insert(pos, e);
      end
    end else if (held.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      e = held.pop_front();
      r.key = e.key;
      r.payload = e.payload;
    end
    r.count = spq_pkg::COUNT_W'(held.size());
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return KEY_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_req(input spq_pkg::opcode_t op, input logic [KEY_W-1:0] key,
                          input logic [PAY_W-1:0] pay, input bit use_fixed,
                          input pq_result_t fixed_res);
    pq_result_t res;
    int         gap;
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_key     <= key;
    in_payload <= pay;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = apply_request(op, key, pay);
    if (use_fixed) res = fixed_res;
    pending_results.push_back(res);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (in_valid !== 1'b0) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cap(input logic [spq_pkg::CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_reg = value;
  endtask

  initial begin
    int                        ph;
    int                        n;
    int                        ins_pct;
    logic [spq_pkg::CAP_W-1:0] new_cap;
    spq_pkg::opcode_t          op;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < DIR_ROWS; n++) begin
      if (dir_tab[n].kind == ROW_CFG) begin
        drain_results();
        write_cap(dir_tab[n].cap);
      end else begin
        send_req(dir_tab[n].op, dir_tab[n].key, dir_tab[n].payload,
                 dir_tab[n].fixed, dir_tab[n].want);
      end
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: new_cap = 5'd16;
        1: new_cap = 5'd0;
        2: new_cap = 5'd31;
        3: new_cap = 5'd1;
        default: new_cap = spq_pkg::CAP_W'($urandom_range(0, 31));
      endcase
      write_cap(new_cap);
      no_idle = (ph == 4) || ($urandom_range(0, 5) == 0);
      case (ph % 3)
        0: ins_pct = 70;
        1: ins_pct = 30;
        default: ins_pct = 50;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // occasionally hold off until every request has answered
        if ($urandom_range(0, 199) == 0) drain_results();
        op = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        send_req(op, pick_key(), PAY_W'($urandom_range(0, 65535)), 1'b0, blank_result);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) stall_left--;
    else stall_left = pick_gap();
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    pq_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: status %0d key %h payload %h count %0d",
                   out_status, out_key, out_payload, out_count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_key !== want.key ||
            out_payload !== want.payload || out_count !== want.count) begin
          if (mismatches < 10)
            $display("mismatch: exp status %0d key %h payload %h count %0d, got %0d %h %h %0d",
                     want.status, want.key, want.payload, want.count,
                     out_status, out_key, out_payload, out_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
